FILE: sv/assert_macros.svh
// Assertion helper macros for the toroidal life block.
// Used by RTL files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge, disabled while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

FILE: sv/tlgs_pkg.sv
// Shared types, constants and helpers for the toroidal life block.
// No dependencies.
package tlgs_pkg;

  localparam int NUM_COLS    = 64;
  localparam int NUM_ROWS    = 64;
  localparam int COL_AW      = $clog2(NUM_COLS);
  localparam int ROW_AW      = $clog2(NUM_ROWS);
  localparam int SIZE_W      = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

  typedef logic [NUM_COLS-1:0] row_t;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_ADV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    row_t              wr_data;
    logic              clr;
  } mem_req_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > maxv) return maxv;
    return v;
  endfunction

endpackage

FILE: sv/tlgs_grid_mem.sv
// Grid row memory: one row per entry, one write and one registered read port.
// Per-row valid bits make unwritten or cleared rows read as all dead. Uses tlgs_pkg.
module tlgs_grid_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  tlgs_pkg::mem_req_t req,
  output tlgs_pkg::row_t     rd_data
);
  import tlgs_pkg::*;

  row_t                grid_r [NUM_ROWS];
  logic [NUM_ROWS-1:0] vld_r;
  row_t                rd_row_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      grid_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_row_r <= grid_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_row_r : '0;

endmodule

FILE: sv/tlgs_row_update.sv
// B3/S23 update of one grid row from a three-row window, columns wrap at ncols.
// Columns at or beyond ncols keep their old value. Uses tlgs_pkg.
module tlgs_row_update (
  input  tlgs_pkg::row_t                   top_row,
  input  tlgs_pkg::row_t                   mid_row,
  input  tlgs_pkg::row_t                   bot_row,
  input  logic [tlgs_pkg::SIZE_W-1:0]      ncols,
  output tlgs_pkg::row_t                   new_row
);
  import tlgs_pkg::*;

  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_CNT = 4'd2;

  logic [COL_AW-1:0] last_col;

  assign last_col = COL_AW'(ncols - SIZE_W'(1));

  always_comb begin
    logic       tl, tr, ml, mr, bl, br;
    logic [3:0] cnt;
    for (int c = 0; c < NUM_COLS; c++) begin
      if (c == 0) begin
        tl = top_row[last_col];
        ml = mid_row[last_col];
        bl = bot_row[last_col];
      end else begin
        tl = top_row[(c + NUM_COLS - 1) % NUM_COLS];
        ml = mid_row[(c + NUM_COLS - 1) % NUM_COLS];
        bl = bot_row[(c + NUM_COLS - 1) % NUM_COLS];
      end
      if (COL_AW'(c) == last_col || c == NUM_COLS - 1) begin
        tr = top_row[0];
        mr = mid_row[0];
        br = bot_row[0];
      end else begin
        tr = top_row[(c + 1) % NUM_COLS];
        mr = mid_row[(c + 1) % NUM_COLS];
        br = bot_row[(c + 1) % NUM_COLS];
      end
      cnt = 4'(tl) + 4'(top_row[c]) + 4'(tr) + 4'(ml) + 4'(mr)
          + 4'(bl) + 4'(bot_row[c]) + 4'(br);
      if (SIZE_W'(c) < ncols) begin
        new_row[c] = (cnt == BIRTH_CNT) || (mid_row[c] && cnt == SURVIVE_CNT);
      end else begin
        new_row[c] = mid_row[c];
      end
    end
  end

endmodule

FILE: sv/toroidal_life_generation_step.sv
// Top level of the toroidal B3/S23 life block: sequencer, config registers, result register.
// Depends on tlgs_pkg, tlgs_grid_mem, tlgs_row_update and assert_macros.svh.
//
// Usage:
//   in_*  : one transaction per operation (write cell, read cell, advance, clear).
//   out_* : exactly one result transaction per operation, in order.
//   cfg_* : cols/rows in use, written by the user only while the block is idle; not enforced.
// Steps from the accepting edge to out_tvalid, receiver ready:
//   cell write/read in range: row read, then modify or select, then result loaded.
//   out-of-range cell access and clear: result loaded straight after acceptance.
//   advance: a sweep over the nrows rows in use (clamped to 3..64), one grid
//   row read and one written per cycle, with a three-row window feeding the update.
// One operation is in flight at a time; in_tready is high only when idle, so the
// next transaction can be taken in the cycle after the result is loaded.
// A finished result sits in the output register; if the receiver stalls, the
// next result waits inside until the output register is taken.
// Reset: grid all dead (per-row valid bits, no clearing pass), 64 x 64 in use.
`include "assert_macros.svh"

module toroidal_life_generation_step (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] operation, [7:2] col, [13:8] row, [14] value, [15] zero
  input  logic [tlgs_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] cell_value, [1] out_of_range, [7:2] zero
  output logic [tlgs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_we,
  input  logic [tlgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlgs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tlgs_pkg::*;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   step_r, step_nxt;
  logic [SIZE_W-1:0]   cols_r, rows_r;
  logic [SIZE_W-1:0]   ncols, nrows, nrows_p1, shift_last, adv_last;
  logic [ROW_AW-1:0]   nrows_m1;

  op_t                 op_r;
  logic [COL_AW-1:0]   col_r;
  logic [ROW_AW-1:0]   row_r;
  logic                val_r;

  op_t                 in_op;
  logic [COL_AW-1:0]   in_col;
  logic [ROW_AW-1:0]   in_row;
  logic                in_val;
  logic                in_oor;

  row_t                top_r, top_nxt, mid_r, mid_nxt, bot_r, bot_nxt;
  row_t                first_r, first_nxt, row0_r, row0_nxt;
  row_t                shift_in, rd_data, new_row;
  mem_req_t            mreq;

  logic                res_cell_r, res_cell_nxt, res_oor_r, res_oor_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_cell_r, out_cell_nxt, out_oor_r, out_oor_nxt;

  assign in_op  = op_t'(in_tdata[1:0]);
  assign in_col = in_tdata[7:2];
  assign in_row = in_tdata[13:8];
  assign in_val = in_tdata[14];

  assign ncols      = clamp_size(cols_r, SIZE_W'(NUM_COLS));
  assign nrows      = clamp_size(rows_r, SIZE_W'(NUM_ROWS));
  assign nrows_m1   = ROW_AW'(nrows - SIZE_W'(1));
  assign nrows_p1   = nrows + SIZE_W'(1);
  assign shift_last = nrows + SIZE_W'(2);
  assign adv_last   = nrows + SIZE_W'(3);
  assign in_oor     = (SIZE_W'(in_col) >= ncols) || (SIZE_W'(in_row) >= nrows);

  tlgs_grid_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .rd_data (rd_data)
  );

  tlgs_row_update u_upd (
    .top_row (top_r),
    .mid_row (mid_r),
    .bot_row (bot_r),
    .ncols   (ncols),
    .new_row (new_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= SIZE_W'(NUM_COLS);
      rows_r <= SIZE_W'(NUM_ROWS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS: cols_r <= cfg_data;
        CFG_ROWS: rows_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_op;
      col_r <= in_col;
      row_r <= in_row;
      val_r <= in_val;
    end
    top_r      <= top_nxt;
    mid_r      <= mid_nxt;
    bot_r      <= bot_nxt;
    first_r    <= first_nxt;
    row0_r     <= row0_nxt;
    res_cell_r <= res_cell_nxt;
    res_oor_r  <= res_oor_nxt;
    out_cell_r <= out_cell_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    top_nxt       = top_r;
    mid_nxt       = mid_r;
    bot_nxt       = bot_r;
    first_nxt     = first_r;
    row0_nxt      = row0_r;
    res_cell_nxt  = res_cell_r;
    res_oor_nxt   = res_oor_r;
    out_valid_nxt = out_valid_r;
    out_cell_nxt  = out_cell_r;
    out_oor_nxt   = out_oor_r;
    shift_in      = '0;
    mreq          = '0;
    in_tready     = (state_r == ST_IDLE);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          res_cell_nxt = 1'b0;
          res_oor_nxt  = 1'b0;
          unique case (in_op) inside
            OP_WRITE, OP_READ: begin
              if (in_oor) begin
                res_oor_nxt = 1'b1;
                state_nxt   = ST_FIN;
              end else begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = in_row;
                state_nxt    = ST_CELL;
              end
            end
            OP_ADVANCE: begin
              step_nxt  = '0;
              state_nxt = ST_ADV;
            end
            OP_CLEAR: begin
              mreq.clr  = 1'b1;
              state_nxt = ST_FIN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CELL: begin
        if (op_r == OP_WRITE) begin
          mreq.wr_en          = 1'b1;
          mreq.wr_addr        = row_r;
          mreq.wr_data        = rd_data;
          mreq.wr_data[col_r] = val_r;
        end else begin
          res_cell_nxt = rd_data[col_r];
        end
        state_nxt = ST_FIN;
      end
      ST_ADV: begin
        // read order: last row, then rows 0 .. last-1
        if (step_r < nrows) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = (step_r == '0) ? nrows_m1 : ROW_AW'(step_r - SIZE_W'(1));
        end
        // window input: memory rows, then saved old last row and old row 0
        if (step_r != '0 && step_r <= shift_last) begin
          if (step_r <= nrows) begin
            shift_in = rd_data;
          end else if (step_r == nrows_p1) begin
            shift_in = first_r;
          end else begin
            shift_in = row0_r;
          end
          top_nxt = mid_r;
          mid_nxt = bot_r;
          bot_nxt = shift_in;
          if (step_r == SIZE_W'(1)) begin
            first_nxt = rd_data;
          end
          if (step_r == SIZE_W'(2)) begin
            row0_nxt = rd_data;
          end
        end
        if (step_r >= SIZE_W'(4)) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = ROW_AW'(step_r - SIZE_W'(4));
          mreq.wr_data = new_row;
        end
        if (step_r == adv_last) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + SIZE_W'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = res_cell_r;
          out_oor_nxt   = res_oor_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - 2)'(0), out_oor_r, out_cell_r};

  `ASSERT_CLK(a_adv_step_bound, (state_r == ST_ADV) |-> (step_r <= adv_last),
              "advance step counter past end of sweep")
  `ASSERT_CLK(a_adv_wr_in_area,
              (state_r == ST_ADV && mreq.wr_en) |-> (SIZE_W'(mreq.wr_addr) < nrows),
              "advance writes a row outside the area in use")
  `ASSERT_NEVER(a_no_rw_same_row, mreq.rd_en && mreq.wr_en && (mreq.rd_addr == mreq.wr_addr),
                "row read and written in the same cycle")
  `ASSERT_CLK(a_bulk_result_zero,
              (state_r == ST_FIN && (op_r == OP_ADVANCE || op_r == OP_CLEAR))
                |-> (!res_cell_r && !res_oor_r),
              "advance or clear result not zero")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for toroidal_life_generation_step (B3/S23 life on a torus).
// Holds its own cell grid and size registers and predicts every result transaction.
// Depends on tlgs_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module testbench;
  import tlgs_pkg::*;

  typedef struct {
    op_t        op;
    logic [5:0] col;
    logic [5:0] row;
    logic       value;
  } cell_req_t;

  typedef struct {
    logic cell_value;
    logic out_of_range;
  } cell_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cell_req_t op_queue[$];
  cell_rsp_t due_results[$];
  cell_req_t cur_req;
  row_t life_grid[NUM_ROWS];
  row_t prev_gen[NUM_ROWS];
  logic [SIZE_W-1:0] cols_reg = SIZE_W'(64);
  logic [SIZE_W-1:0] rows_reg = SIZE_W'(64);
  int n_accepted = 0;
  int err_cnt = 0;
  logic calm;

  toroidal_life_generation_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // no random idling on either side during this window of transactions
  assign calm = (n_accepted >= 450) && (n_accepted < 650);

  function automatic int size_in_use(logic [SIZE_W-1:0] v, int maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic cell_rsp_t apply_life_op(cell_req_t req);
    cell_rsp_t rsp;
    int nc;
    int nr;
    int cnt;
    int rr;
    int cc;
    rsp.cell_value = 1'b0;
    rsp.out_of_range = 1'b0;
    nc = size_in_use(cols_reg, NUM_COLS);
    nr = size_in_use(rows_reg, NUM_ROWS);
    case (req.op) inside
      OP_WRITE, OP_READ: begin
        if (req.col >= nc || req.row >= nr) begin
          rsp.out_of_range = 1'b1;
        end else if (req.op == OP_WRITE) begin
          life_grid[req.row][req.col] = req.value;
        end else begin
          rsp.cell_value = life_grid[req.row][req.col];
        end
      end
      OP_ADVANCE: begin
        prev_gen = life_grid;
        for (int r = 0; r < nr; r++) begin
          for (int c = 0; c < nc; c++) begin
            cnt = 0;
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0) begin
                  rr = (r + dr + nr) % nr;
                  cc = (c + dc + nc) % nc;
                  cnt += prev_gen[rr][cc];
                end
              end
            end
            life_grid[r][c] = (cnt == 3) || (prev_gen[r][c] && cnt == 2);
          end
        end
      end
      default: begin
        for (int r = 0; r < NUM_ROWS; r++) life_grid[r] = '0;
      end
    endcase
    return rsp;
  endfunction

  // Driver: one transaction per operation, random gaps outside the calm window.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(apply_life_op(cur_req));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (op_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 28)) begin
          cur_req = op_queue.pop_front();
          in_tdata <= {1'b0, cur_req.value, cur_req.row, cur_req.col, cur_req.op};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    cell_rsp_t exp_rsp;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result transaction: tdata=%h", out_tdata);
          err_cnt++;
        end else begin
          exp_rsp = due_results.pop_front();
          if (out_tdata[0] !== exp_rsp.cell_value) begin
            $error("cell_value: expected %b, actual %b", exp_rsp.cell_value, out_tdata[0]);
            err_cnt++;
          end
          if (out_tdata[1] !== exp_rsp.out_of_range) begin
            $error("out_of_range: expected %b, actual %b", exp_rsp.out_of_range,
                   out_tdata[1]);
            err_cnt++;
          end
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  task automatic push_op(op_t op, int col, int row, logic value);
    cell_req_t req;
    req.op = op;
    req.col = col[5:0];
    req.row = row[5:0];
    req.value = value;
    op_queue.push_back(req);
  endtask

  task automatic wait_drained(int tail);
    do @(negedge clk);
    while (op_queue.size() != 0 || in_tvalid || due_results.size() != 0);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COLS) cols_reg = val;
    else rows_reg = val;
    @(negedge clk);
  endtask

  // Mostly seeded patterns evolved and read back, the rest noise.
  task automatic random_phase(int n_items);
    int nc;
    int nr;
    int oc;
    int orow;
    int cnt;
    int pick;
    nc = size_in_use(cols_reg, NUM_COLS);
    nr = size_in_use(rows_reg, NUM_ROWS);
    cnt = 0;
    while (cnt < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        oc = $urandom_range(0, nc - 1);
        orow = $urandom_range(0, nr - 1);
        repeat ($urandom_range(3, 12)) begin
          push_op(OP_WRITE, (oc + $urandom_range(0, 3)) % nc,
                  (orow + $urandom_range(0, 3)) % nr, $urandom_range(0, 3) != 0);
          cnt++;
        end
        repeat ($urandom_range(1, 3)) begin
          push_op(OP_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
          cnt++;
        end
        repeat ($urandom_range(2, 8)) begin
          push_op(OP_READ, (oc + $urandom_range(0, 5) + nc - 1) % nc,
                  (orow + $urandom_range(0, 5) + nr - 1) % nr, 1'($urandom_range(0, 1)));
          cnt++;
        end
      end else if (pick < 70) begin
        push_op(OP_READ, $urandom_range(0, nc - 1), $urandom_range(0, nr - 1),
                1'($urandom_range(0, 1)));
        cnt++;
      end else if (pick < 87) begin
        push_op(op_t'($urandom_range(0, 1)), $urandom_range(0, 63), $urandom_range(0, 63),
                1'($urandom_range(0, 1)));
        cnt++;
      end else if (pick < 91) begin
        push_op(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                1'($urandom_range(0, 1)));
        cnt++;
      end else begin
        push_op(OP_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                1'($urandom_range(0, 1)));
        cnt++;
      end
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] cols_set[8];
    logic [SIZE_W-1:0] rows_set[8];
    cols_set = '{7'd64, 7'd3, 7'd127, 7'd0, 7'd5, 7'd4, 7'd9, 7'd64};
    rows_set = '{7'd64, 7'd3, 7'd0, 7'd127, 7'd5, 7'd11, 7'd4, 7'd64};
    for (int r = 0; r < NUM_ROWS; r++) life_grid[r] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corners are diagonal neighbors across the wrap; a blinker across the column seam
    push_op(OP_READ, 0, 0, 1'b1);
    push_op(OP_WRITE, 0, 0, 1'b1);
    push_op(OP_WRITE, 63, 63, 1'b1);
    push_op(OP_READ, 63, 63, 1'b0);
    push_op(OP_READ, 63, 0, 1'b0);
    push_op(OP_ADVANCE, 0, 0, 1'b0);
    push_op(OP_READ, 0, 0, 1'b0);
    push_op(OP_WRITE, 63, 0, 1'b1);
    push_op(OP_WRITE, 0, 0, 1'b1);
    push_op(OP_WRITE, 1, 0, 1'b1);
    push_op(OP_ADVANCE, 63, 63, 1'b1);
    push_op(OP_READ, 0, 63, 1'b0);
    push_op(OP_READ, 63, 0, 1'b0);
    push_op(OP_WRITE, 10, 10, 1'b1);
    wait_drained(8);

    // sizes below the minimum act as 3 x 3
    write_size(CFG_COLS, 7'd0);
    write_size(CFG_ROWS, 7'd0);
    push_op(OP_WRITE, 1, 1, 1'b1);
    push_op(OP_WRITE, 3, 0, 1'b1);
    push_op(OP_READ, 0, 63, 1'b0);
    push_op(OP_READ, 10, 10, 1'b0);
    push_op(OP_ADVANCE, 0, 0, 1'b0);
    push_op(OP_READ, 1, 1, 1'b0);
    wait_drained(8);

    // grow back: cells outside the old area were kept, then clear removes them
    write_size(CFG_COLS, 7'd127);
    write_size(CFG_ROWS, 7'd127);
    push_op(OP_READ, 10, 10, 1'b0);
    push_op(OP_CLEAR, 63, 63, 1'b1);
    push_op(OP_READ, 10, 10, 1'b1);
    push_op(OP_READ, 0, 63, 1'b1);
    wait_drained(8);

    for (int p = 0; p < 8; p++) begin
      if (p >= 4 && p < 7 && $urandom_range(0, 1)) begin
        cols_set[p] = SIZE_W'($urandom_range(0, 20));
        rows_set[p] = SIZE_W'($urandom_range(0, 20));
      end
      write_size(CFG_COLS, cols_set[p]);
      write_size(CFG_ROWS, rows_set[p]);
      random_phase(135);
      wait_drained(8);
    end

    wait_drained(80);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/tlgs_pkg.sv
sv/tlgs_grid_mem.sv
sv/tlgs_row_update.sv
sv/toroidal_life_generation_step.sv
tb/testbench.sv
